[rtl/core/cft_pkg.sv]
// types, constants and register indexes shared by the csv field tokenizer
`default_nettype none

package cft_pkg;

  localparam int unsigned CharW     = 8;
  localparam int unsigned CountW    = 8;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 8;

  // field count saturates at the lesser of the field limit and the count range
  localparam int unsigned MaxFields = 255;
  localparam int unsigned CountMax  = (1 << CountW) - 1;
  localparam int unsigned FieldCap  = (MaxFields < CountMax) ? MaxFields : CountMax;

  localparam logic [CharW-1:0] SepReset   = 8'd44;
  localparam logic [CharW-1:0] QuoteReset = 8'd34;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSeparator = 1'b0,
    CfgQuote     = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             end_of_line;
  } in_item_t;

  typedef struct packed {
    logic              char_valid;
    logic [CharW-1:0]  out_char;
    logic              field_end;
    logic              field_empty;
    logic              line_done;
    logic [CountW-1:0] field_total;
    logic              parse_error;
  } out_item_t;

  typedef struct packed {
    logic              at_line_start;
    logic              at_field_start;
    logic              in_quoted_field;
    logic              quote_pending;
    logic              field_has_data;
    logic              error_seen;
    logic [CountW-1:0] field_counter;
  } line_state_t;

  typedef struct packed {
    logic [CharW-1:0] separator_char;
    logic [CharW-1:0] quote_char;
  } cfg_t;

  localparam line_state_t LineReset = '{
    at_line_start:   1'b1,
    at_field_start:  1'b1,
    in_quoted_field: 1'b0,
    quote_pending:   1'b0,
    field_has_data:  1'b0,
    error_seen:      1'b0,
    field_counter:   '0
  };

endpackage

`default_nettype wire

[rtl/core/cft_cfg.sv]
// separator and quote configuration registers
`default_nettype none

module cft_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [cft_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [cft_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output cft_pkg::cfg_t                      cfg_o
);

  cft_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cft_pkg::cfg_reg_e'(cfg_idx_i))
        cft_pkg::CfgSeparator: cfg_d.separator_char = cfg_wdata_i[cft_pkg::CharW-1:0];
        cft_pkg::CfgQuote:     cfg_d.quote_char     = cfg_wdata_i[cft_pkg::CharW-1:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.separator_char <= cft_pkg::SepReset;
      cfg_q.quote_char     <= cft_pkg::QuoteReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/core/cft_step.sv]
// per-character tokenizer step: next line state and one result item
`default_nettype none

module cft_step #(
  parameter int unsigned MaxFields = cft_pkg::MaxFields
) (
  input  wire cft_pkg::cfg_t        cfg_i,
  input  wire cft_pkg::line_state_t state_i,
  input  wire cft_pkg::in_item_t    item_i,
  output cft_pkg::line_state_t      state_o,
  output cft_pkg::out_item_t        result_o
);

  // field count saturates at the lesser of the field limit and the count range
  localparam int unsigned FieldCap =
    (MaxFields < cft_pkg::CountMax) ? MaxFields : cft_pkg::CountMax;

  logic is_sep, is_q, eol;
  logic close_now;
  cft_pkg::line_state_t s;
  cft_pkg::out_item_t   o;

  assign is_sep = (item_i.ch == cfg_i.separator_char);
  assign is_q   = (item_i.ch == cfg_i.quote_char);
  assign eol    = item_i.end_of_line;

  always_comb begin
    s         = state_i;
    o         = '0;
    close_now = 1'b0;

    if (s.at_field_start) begin
      if (is_sep) begin
        // leading separator is malformed
        if (s.at_line_start) s.error_seen = 1'b1;
        s.field_has_data = 1'b0;
        close_now = 1'b1;
        if (eol) s.error_seen = 1'b1;
      end else if (is_q) begin
        s.in_quoted_field = 1'b1;
        s.field_has_data  = 1'b0;
        s.at_field_start  = 1'b0;
      end else begin
        o.char_valid     = 1'b1;
        o.out_char       = item_i.ch;
        s.field_has_data = 1'b1;
        s.at_field_start = 1'b0;
      end
    end else if (s.quote_pending) begin
      s.quote_pending = 1'b0;
      if (is_sep) begin
        if (!s.in_quoted_field) s.error_seen = 1'b1;
        close_now = 1'b1;
        if (eol) s.error_seen = 1'b1;
      end else if (is_q) begin
        // doubled quote
        o.char_valid     = 1'b1;
        o.out_char       = cfg_i.quote_char;
        s.field_has_data = 1'b1;
      end else begin
        // stray quote, byte goes through
        s.error_seen     = 1'b1;
        o.char_valid     = 1'b1;
        o.out_char       = item_i.ch;
        s.field_has_data = 1'b1;
      end
    end else if (s.in_quoted_field) begin
      if (is_q) begin
        s.quote_pending = 1'b1;
      end else begin
        o.char_valid     = 1'b1;
        o.out_char       = item_i.ch;
        s.field_has_data = 1'b1;
      end
    end else begin
      if (is_sep) begin
        close_now = 1'b1;
        if (eol) s.error_seen = 1'b1;
      end else if (is_q) begin
        s.quote_pending = 1'b1;
      end else begin
        o.char_valid     = 1'b1;
        o.out_char       = item_i.ch;
        s.field_has_data = 1'b1;
      end
    end
    s.at_line_start = 1'b0;

    // line end closes a still open field
    if (eol && !close_now) begin
      if (s.quote_pending) begin
        if (!s.in_quoted_field) s.error_seen = 1'b1;
      end else if (s.in_quoted_field) begin
        s.error_seen = 1'b1;
      end
      close_now = 1'b1;
    end

    if (close_now) begin
      o.field_end   = s.field_has_data;
      o.field_empty = !s.field_has_data;
      if (s.field_counter < cft_pkg::CountW'(FieldCap)) begin
        s.field_counter = s.field_counter + cft_pkg::CountW'(1);
      end
      s.field_has_data  = 1'b0;
      s.in_quoted_field = 1'b0;
      s.quote_pending   = 1'b0;
      s.at_field_start  = 1'b1;
    end

    o.parse_error = s.error_seen;
    if (eol) begin
      o.line_done   = 1'b1;
      o.field_total = s.field_counter;
      s             = cft_pkg::LineReset;
    end
  end

  assign state_o  = s;
  assign result_o = o;

endmodule

`default_nettype wire

[rtl/core/csv_field_tokenizer.sv]
// top level of the streaming csv field tokenizer
//
// usage:
//   input channel: one raw byte per transfer plus an end-of-line flag. a
//   transfer happens at a rising edge with in_valid_i high and in_stall_o low.
//   output channel: one result item per input item, in order: content byte
//   with char_valid, field end / empty field marks, line_done with the field
//   count, and the sticky parse error of the line so far.
//   config port: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//   (0 separator, 1 quote) at the edge; write only while the block is idle.
//   path: a byte taken from the input moves into the input register and then
//   into the result register (one input register, one result register).
//   throughput: one byte per cycle while the output is not stalled; the state
//   update between the input register and the result register is combinational.
//   reset: line state returns to line start, separator 44, quote 34.
//   stall: a held result keeps its value; the input register still takes one
//   more byte, and in_stall_o rises only once both registers are full.
`default_nettype none

module csv_field_tokenizer #(
  parameter int unsigned MaxFields = cft_pkg::MaxFields
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire cft_pkg::in_item_t             in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output cft_pkg::out_item_t                 out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [cft_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [cft_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  cft_pkg::cfg_t        cfg;
  cft_pkg::line_state_t state_q, state_d;
  cft_pkg::out_item_t   step_result;

  // input register
  logic                 in_valid_q;
  cft_pkg::in_item_t    in_data_q;
  // result register
  logic                 out_valid_q;
  cft_pkg::out_item_t   out_data_q;

  logic advance;
  logic in_take;

  cft_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  cft_step #(
    .MaxFields (MaxFields)
  ) u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (in_data_q),
    .state_o  (state_d),
    .result_o (step_result)
  );

  // item moves into the result register when that slot is free or draining
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= cft_pkg::LineReset;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) in_data_q <= in_data_i;
    if (advance) out_data_q <= step_result;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  // a finished line leaves the state at line start
  a_line_reset : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_data_q.end_of_line |=> state_q == cft_pkg::LineReset)
    else $error("line state not cleared after line end");

  // error stays set until the line ends
  a_err_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !in_data_q.end_of_line && state_q.error_seen |=> state_q.error_seen)
    else $error("sticky error dropped within a line");

  // a field closes as either empty or non-empty, never both
  a_close_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.field_end && out_data_o.field_empty))
    else $error("field marked both empty and non-empty");

  // a content byte never comes with an empty field mark
  a_char_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.char_valid |-> !out_data_o.field_empty)
    else $error("content byte on an empty field");
`endif

endmodule

`default_nettype wire

[dv/csv_field_tokenizer_tb.sv]
// testbench for the csv field tokenizer: directed and random lines checked against a predictor
module csv_field_tokenizer_tb;

  // random bytes per separator/quote setting, and the run timeout in clock cycles
  localparam int unsigned PhaseItems = 170;
  localparam int unsigned CycleLimit = 400000;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_stall_o;
  cft_pkg::in_item_t            in_data_i   = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  cft_pkg::out_item_t           out_data_o;
  logic                         cfg_we_i    = 1'b0;
  logic [cft_pkg::CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [cft_pkg::CfgDataW-1:0] cfg_wdata_i = '0;

  csv_field_tokenizer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor copy of the registers and the per-line state
  logic [cft_pkg::CharW-1:0] sep_char   = cft_pkg::SepReset;
  logic [cft_pkg::CharW-1:0] quote_char = cft_pkg::QuoteReset;
  cft_pkg::line_state_t      line_st    = cft_pkg::LineReset;
  cft_pkg::out_item_t        token;    // result under construction for the current byte

  cft_pkg::in_item_t         pending_q[$];   // bytes waiting to be driven
  cft_pkg::out_item_t        expect_q[$];    // predicted results, oldest first
  logic [cft_pkg::CharW-1:0] line_buf[$];    // line being assembled by the generator
  cft_pkg::out_item_t        wanted;

  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  int unsigned queued     = 0;

  // transfer flags from the last rising edge, used by the falling-edge drivers
  logic        in_fire   = 1'b0;
  logic        out_fire  = 1'b0;
  int unsigned in_gap    = 0;
  int unsigned out_hold  = 0;
  logic        in_burst  = 1'b0;
  logic        out_burst = 1'b0;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // content byte goes out and marks the field as non-empty
  function automatic void take_char(logic [cft_pkg::CharW-1:0] c);
    token.char_valid = 1'b1;
    token.out_char   = c;
    line_st.field_has_data = 1'b1;
  endfunction

  // close the current field: mark it, count it (saturating), back to field start
  function automatic void end_field();
    if (line_st.field_has_data) begin
      token.field_end = 1'b1;
    end else begin
      token.field_empty = 1'b1;
    end
    if (line_st.field_counter < cft_pkg::FieldCap) begin
      line_st.field_counter = line_st.field_counter + cft_pkg::CountW'(1);
    end
    line_st.field_has_data  = 1'b0;
    line_st.in_quoted_field = 1'b0;
    line_st.quote_pending   = 1'b0;
    line_st.at_field_start  = 1'b1;
  endfunction

  function automatic cft_pkg::out_item_t tokenize(cft_pkg::in_item_t item);
    logic is_sep;
    logic is_quote;
    logic open_field;
    // a byte equal to both codes is a separator wherever one is looked for first
    is_sep     = (item.ch == sep_char);
    is_quote   = (item.ch == quote_char);
    open_field = 1'b1;
    token      = '0;
    if (line_st.at_field_start) begin
      if (is_sep) begin
        // empty field; an error when it leads the line
        if (line_st.at_line_start) begin
          line_st.error_seen = 1'b1;
        end
        line_st.field_has_data = 1'b0;
        end_field();
        open_field = 1'b0;
      end else if (is_quote) begin
        line_st.in_quoted_field = 1'b1;
        line_st.field_has_data  = 1'b0;
        line_st.at_field_start  = 1'b0;
      end else begin
        take_char(item.ch);
        line_st.at_field_start = 1'b0;
      end
    end else if (line_st.quote_pending) begin
      line_st.quote_pending = 1'b0;
      if (is_sep) begin
        // quote then separator closes a quoted field, is stray in an unquoted one
        if (!line_st.in_quoted_field) begin
          line_st.error_seen = 1'b1;
        end
        end_field();
        open_field = 1'b0;
      end else if (is_quote) begin
        // doubled quote gives one quote byte
        take_char(quote_char);
      end else begin
        // stray quote: dropped, the following byte goes through
        line_st.error_seen = 1'b1;
        take_char(item.ch);
      end
    end else if (line_st.in_quoted_field) begin
      if (is_quote) begin
        line_st.quote_pending = 1'b1;
      end else begin
        take_char(item.ch);
      end
    end else if (is_sep) begin
      end_field();
      open_field = 1'b0;
    end else if (is_quote) begin
      line_st.quote_pending = 1'b1;
    end else begin
      take_char(item.ch);
    end
    line_st.at_line_start = 1'b0;

    // separator as the last byte of the line: trailing separator
    if (item.end_of_line && !open_field) begin
      line_st.error_seen = 1'b1;
    end
    if (item.end_of_line && open_field) begin
      // a pending quote closes a quoted field but is stray in an unquoted one;
      // a quoted field with no closing quote is unclosed
      if (line_st.quote_pending ? !line_st.in_quoted_field : line_st.in_quoted_field) begin
        line_st.error_seen = 1'b1;
      end
      end_field();
    end
    token.parse_error = line_st.error_seen;
    if (item.end_of_line) begin
      token.line_done   = 1'b1;
      token.field_total = line_st.field_counter;
      line_st           = cft_pkg::LineReset;
    end
    return token;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [cft_pkg::CharW-1:0] want,
                                      logic [cft_pkg::CharW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // rising edge: note transfers, predict accepted bytes, check accepted results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_fire  <= in_valid_i && !in_stall_o;
      out_fire <= out_valid_o && !out_stall_i;
      if (in_valid_i && !in_stall_o) begin
        expect_q = {expect_q, tokenize(in_data_i)};
      end
      if (out_valid_o && !out_stall_i) begin
        if (expect_q.size() == 0) begin
          $error("result transfer with no prediction waiting");
          mismatches++;
        end else begin
          wanted = expect_q.pop_front();
          check_field("char_valid",  wanted.char_valid,  out_data_o.char_valid);
          check_field("out_char",    wanted.out_char,    out_data_o.out_char);
          check_field("field_end",   wanted.field_end,   out_data_o.field_end);
          check_field("field_empty", wanted.field_empty, out_data_o.field_empty);
          check_field("line_done",   wanted.line_done,   out_data_o.line_done);
          check_field("field_total", wanted.field_total, out_data_o.field_total);
          check_field("parse_error", wanted.parse_error, out_data_o.parse_error);
        end
      end
    end
  end

  // timeout guard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers, both on the falling edge
  // ---------------------------------------------------------------------------

  // byte sender: holds a stalled byte, otherwise waits out its gap then loads the next
  always @(negedge clk_i) begin
    if (rst_ni) begin
      // occasional switch into or out of a no-gap burst
      if ($urandom_range(0, 39) == 0) begin
        in_burst = ~in_burst;
      end
      if (in_valid_i && !in_fire) begin
        // byte not taken yet, payload stays put
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_q.size() > 0) begin
        in_data_i  <= pending_q.pop_front();
        in_valid_i <= 1'b1;
        in_gap = in_burst ? 0 : $urandom_range(0, 13);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver: after each result transfer draws a stall for the next one
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ($urandom_range(0, 39) == 0) begin
        out_burst = ~out_burst;
      end
      if (out_fire) begin
        out_hold = out_burst ? 0 : $urandom_range(0, 13);
      end
      if (out_hold > 0) begin
        out_hold--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // send the assembled line, end-of-line on its last byte
  task automatic push_line();
    cft_pkg::in_item_t item;
    foreach (line_buf[i]) begin
      item.ch          = line_buf[i];
      item.end_of_line = (i == line_buf.size() - 1);
      pending_q = {pending_q, item};
    end
    queued += line_buf.size();
    line_buf.delete();
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      line_buf = {line_buf, s[i]};
    end
    push_line();
  endtask

  // any byte that is neither separator nor quote
  function automatic logic [cft_pkg::CharW-1:0] plain_byte();
    logic [cft_pkg::CharW-1:0] b;
    do begin
      b = cft_pkg::CharW'($urandom_range(0, 255));
    end while (b == sep_char || b == quote_char);
    return b;
  endfunction

  // one random line: mostly well-formed fields with random content, some noise
  task automatic make_line();
    int unsigned               nf;
    int unsigned               len;
    int unsigned               kind;
    logic [cft_pkg::CharW-1:0] rb;
    if ($urandom_range(0, 5) == 0) begin
      // noise heavy in separators and quotes
      len = $urandom_range(1, 8);
      repeat (len) begin
        rb = cft_pkg::CharW'($urandom_range(0, 255));
        case ($urandom_range(0, 2))
          0:       line_buf = {line_buf, sep_char};
          1:       line_buf = {line_buf, quote_char};
          default: line_buf = {line_buf, rb};
        endcase
      end
    end else begin
      nf = $urandom_range(1, 6);
      for (int f = 0; f < nf; f++) begin
        if (f != 0) begin
          line_buf = {line_buf, sep_char};
        end
        kind = $urandom_range(0, 5);
        if (kind == 0) begin
          // empty field; leading or trailing ones make broken lines
        end else if (kind <= 2) begin
          // quoted field with doubled quotes and separators inside
          line_buf = {line_buf, quote_char};
          len = $urandom_range(0, 5);
          repeat (len) begin
            case ($urandom_range(0, 4))
              0: begin
                line_buf = {line_buf, quote_char, quote_char};
              end
              1:       line_buf = {line_buf, sep_char};
              default: line_buf = {line_buf, plain_byte()};
            endcase
          end
          line_buf = {line_buf, quote_char};
        end else begin
          len = $urandom_range(1, 5);
          repeat (len) line_buf = {line_buf, plain_byte()};
        end
      end
      if (line_buf.size() == 0) begin
        line_buf = {line_buf, plain_byte()};
      end
    end
    push_line();
  endtask

  // more fields than the counter holds, so the count saturates
  task automatic make_long_line();
    line_buf = {line_buf, plain_byte()};
    repeat (cft_pkg::FieldCap + 4) begin
      line_buf = {line_buf, sep_char};
      if ($urandom_range(0, 1) == 1) begin
        line_buf = {line_buf, plain_byte()};
      end
    end
    line_buf = {line_buf, plain_byte()};
    push_line();
  endtask

  // waits until every queued byte is sent and every predicted result has come back, then settles
  task automatic drain();
    while (pending_q.size() != 0 || in_valid_i || expect_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cft_pkg::cfg_reg_e idx, logic [cft_pkg::CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == cft_pkg::CfgSeparator) begin
      sep_char = value;
    end else begin
      quote_char = value;
    end
  endtask

  // one register setting followed by random lines, ended by a full drain
  task automatic run_phase(logic [cft_pkg::CharW-1:0] sep, logic [cft_pkg::CharW-1:0] quote,
                           logic with_long_line);
    write_reg(cft_pkg::CfgSeparator, sep);
    write_reg(cft_pkg::CfgQuote, quote);
    queued = 0;
    if (with_long_line) begin
      make_long_line();
    end
    while (queued < PhaseItems) begin
      make_line();
    end
    drain();
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed lines at the reset setting: comma and double quote
    queue_text("a,b");            // plain two-field line
    queue_text(",x");             // leading separator
    queue_text("y,");             // trailing separator
    queue_text("\"q");            // unclosed quote
    queue_text("\"a\"\"b\"");     // doubled quote, closing quote at line end
    queue_text("\"\"");           // empty quoted field
    queue_text("c\"d");           // stray quote inside an unquoted field
    queue_text("c\"");            // stray quote at line end
    queue_text(",");              // lone separator, both leading and trailing
    line_buf = {line_buf, 8'hFF}; // byte extremes as single-byte lines
    push_line();
    line_buf = {line_buf, 8'h00};
    push_line();
    drain();

    // register settings: defaults, both extremes, separator equal to quote, other
    run_phase(8'd44,  8'd34,  1'b1);
    run_phase(8'd0,   8'd255, 1'b0);
    run_phase(8'd255, 8'd0,   1'b0);
    run_phase(8'd9,   8'd9,   1'b0);
    run_phase(8'd124, 8'd39,  1'b0);

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
